FILE: rtl/core/ast_pkg.sv
// Package for the argument string tokeniser: word types, parse state
// and the character and mode codes shared by the step logic and top level.
// No dependencies.
package ast_pkg;

    // Parse mode codes
    localparam logic [2:0] MODE_SKIP      = 3'd0;
    localparam logic [2:0] MODE_PLAIN     = 3'd1;
    localparam logic [2:0] MODE_QUOTE     = 3'd2;
    localparam logic [2:0] MODE_QUOTE_ESC = 3'd3;
    localparam logic [2:0] MODE_ESC_ARG   = 3'd4;
    localparam logic [2:0] MODE_DONE      = 3'd5;

    // Characters with meaning to the parser
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Configuration register indexes
    localparam logic [7:0] REG_MAX_ARGS   = 8'd0;
    localparam logic [7:0] REG_TERMINATOR = 8'd1;

    localparam logic [7:0] MAX_ARGS_RESET   = 8'd16;
    localparam logic [7:0] TERMINATOR_RESET = 8'd10;

    typedef struct packed {
        logic       first_byte;
        logic [7:0] char_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       arg_start;
        logic [7:0] arg_index;
        logic       parse_done;
        logic [7:0] arg_count;
    } out_word_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] open_quote;
        logic [7:0] args_found;
    } parse_state_t;

endpackage

FILE: rtl/core/argument_string_tokenizer_top.sv
// Argument string tokeniser, top level: input register, parse state,
// result register and configuration registers. Depends on ast_pkg, ast_step.
// A word passes from the input register to the result register, moving on only
// when the result register is empty or its word is being taken.
// Throughput: one word per cycle while m_ready keeps the output free; the parse step
// is a single pass of logic between the input register and the result register, state updated alongside.
// Reset (aresetn low, synchronous) empties both registers, clears the parse
// state and loads max_args = 16, terminator_char = 10.
module argument_string_tokenizer_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ast_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ast_pkg::out_word_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import ast_pkg::*;

    in_word_t     in_reg;
    logic         in_valid_reg;
    out_word_t    out_reg;
    logic         out_valid_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    out_word_t    out_next;
    logic [7:0]   max_args_reg;
    logic [7:0]   term_reg;

    logic out_load;
    logic advance;
    logic s_accept;

    assign out_load  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_load;
    assign s_ready   = !in_valid_reg || out_load;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    ast_step u_step (
        .cur_state       (state_reg),
        .in_word         (in_reg),
        .max_args        (max_args_reg),
        .terminator_char (term_reg),
        .next_state      (state_next),
        .out_word        (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_SKIP, open_quote: CH_NUL, args_found: 8'd0};
            max_args_reg  <= MAX_ARGS_RESET;
            term_reg      <= TERMINATOR_RESET;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            // advance the parse state only as the word moves to the result
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_ARGS) begin
                    max_args_reg <= cfg_data;
                end else if (cfg_index == REG_TERMINATOR) begin
                    term_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("result or input register valid after reset");

    a_start_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.arg_start |-> m_data.arg_count == m_data.arg_index + 8'd1)
        else $error("argument count does not follow started index");

    a_start_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.arg_start |-> !m_data.parse_done && m_data.out_byte != CH_NUL)
        else $error("argument started on a stop byte");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_reg.first_byte |=> state_reg.args_found >= $past(state_reg.args_found))
        else $error("argument count fell within a string");

    a_stall_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("parse state moved without a word advancing");

endmodule

FILE: rtl/core/ast_step.sv
// Combinational step of the tokeniser: one input word and the current
// parse state give the result word and the next parse state.
// Depends on ast_pkg.
module ast_step (
    input  ast_pkg::parse_state_t cur_state,
    input  ast_pkg::in_word_t     in_word,
    input  logic [7:0]            max_args,
    input  logic [7:0]            terminator_char,
    output ast_pkg::parse_state_t next_state,
    output ast_pkg::out_word_t    out_word
);
    import ast_pkg::*;

    parse_state_t st;
    logic [7:0]   b;
    logic         is_sep;
    logic         skip_here;

    assign b      = in_word.char_byte;
    assign is_sep = (b == CH_SPACE) || (b == CH_TAB);

    always_comb begin
        // start of a new string clears the state before this byte
        if (in_word.first_byte) begin
            st = '{mode: MODE_SKIP, open_quote: CH_NUL, args_found: 8'd0};
        end else begin
            st = cur_state;
        end

        next_state = st;
        skip_here  = 1'b0;
        out_word   = '{out_byte: b, arg_start: 1'b0, arg_index: 8'd0,
                       parse_done: 1'b0, arg_count: 8'd0};

        unique case (st.mode)
            MODE_SKIP: begin
                skip_here = 1'b1;
            end
            MODE_PLAIN: begin
                if (b == CH_NUL || is_sep || b == terminator_char) begin
                    skip_here = 1'b1;
                end
            end
            MODE_ESC_ARG: begin
                if (b == CH_NUL) begin
                    skip_here = 1'b1;
                end else begin
                    next_state.mode = MODE_SKIP;
                end
            end
            MODE_QUOTE: begin
                if (b == CH_NUL) begin
                    skip_here = 1'b1;
                end else if (b == st.open_quote) begin
                    next_state.mode = MODE_SKIP;
                end else if (b == CH_BSLASH) begin
                    next_state.mode = MODE_QUOTE_ESC;
                end
            end
            MODE_QUOTE_ESC: begin
                if (b == CH_NUL) begin
                    skip_here = 1'b1;
                end else begin
                    next_state.mode = MODE_QUOTE;
                end
            end
            default: begin
                // done, and the unused codes behave as done
                next_state.mode = MODE_DONE;
            end
        endcase

        if (skip_here) begin
            next_state.mode = MODE_SKIP;
            if (st.args_found >= max_args || b == CH_NUL || b == terminator_char) begin
                out_word.out_byte = CH_NUL;
                next_state.mode   = MODE_DONE;
            end else if (is_sep) begin
                out_word.out_byte = CH_NUL;
            end else begin
                out_word.arg_start    = 1'b1;
                out_word.arg_index    = st.args_found;
                next_state.args_found = st.args_found + 8'd1;
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    next_state.open_quote = b;
                    next_state.mode       = MODE_QUOTE;
                end else if (b == CH_BSLASH) begin
                    next_state.mode = MODE_ESC_ARG;
                end else begin
                    next_state.mode = MODE_PLAIN;
                end
            end
        end

        out_word.parse_done = (next_state.mode == MODE_DONE);
        out_word.arg_count  = next_state.args_found;
    end

endmodule

FILE: test/argument_string_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// Testbench for argument_string_tokenizer_top: drives command-line strings byte by byte
// and checks every result word against a scoreboard that tokenises in step.
// Depends on ast_pkg and the top level only.

import ast_pkg::*;

class arg_scoreboard;
    logic [7:0] max_args;
    logic [7:0] term_char;
    logic [2:0] mode;
    logic [7:0] quote_char;
    logic [7:0] args_found;
    out_word_t  pending_words[$];
    int         errors;

    function new();
        max_args   = MAX_ARGS_RESET;
        term_char  = TERMINATOR_RESET;
        mode       = MODE_SKIP;
        quote_char = CH_NUL;
        args_found = 8'd0;
        errors     = 0;
    endfunction

    function bit is_blank(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
        case (idx)
            REG_MAX_ARGS:   max_args = val;
            REG_TERMINATOR: term_char = val;
            default: ;
        endcase
    endfunction

    // Advance the parse by one byte and queue the word it should produce
    function void note_input(in_word_t w);
        logic [7:0] b;
        bit         at_gap;
        out_word_t  exp_w;
        b      = w.char_byte;
        at_gap = 1'b0;
        exp_w  = '{out_byte: b, arg_start: 1'b0, arg_index: 8'd0,
                   parse_done: 1'b0, arg_count: 8'd0};
        if (w.first_byte) begin
            mode       = MODE_SKIP;
            quote_char = CH_NUL;
            args_found = 8'd0;
        end
        case (mode)
            MODE_SKIP: at_gap = 1'b1;
            MODE_PLAIN: begin
                if (b == CH_NUL || is_blank(b) || b == term_char)
                    at_gap = 1'b1;
            end
            MODE_ESC_ARG: begin
                if (b == CH_NUL)
                    at_gap = 1'b1;
                else
                    mode = MODE_SKIP;
            end
            MODE_QUOTE: begin
                if (b == CH_NUL)
                    at_gap = 1'b1;
                else if (b == quote_char)
                    mode = MODE_SKIP;
                else if (b == CH_BSLASH)
                    mode = MODE_QUOTE_ESC;
            end
            MODE_QUOTE_ESC: begin
                if (b == CH_NUL)
                    at_gap = 1'b1;
                else
                    mode = MODE_QUOTE;
            end
            default: mode = MODE_DONE;
        endcase
        if (at_gap) begin
            mode = MODE_SKIP;
            if (args_found >= max_args || b == CH_NUL || b == term_char) begin
                exp_w.out_byte = CH_NUL;
                mode = MODE_DONE;
            end else if (is_blank(b)) begin
                exp_w.out_byte = CH_NUL;
            end else begin
                exp_w.arg_start = 1'b1;
                exp_w.arg_index = args_found;
                args_found = args_found + 8'd1;
                if (b == CH_DQUOTE || b == CH_SQUOTE) begin
                    quote_char = b;
                    mode = MODE_QUOTE;
                end else if (b == CH_BSLASH) begin
                    mode = MODE_ESC_ARG;
                end else begin
                    mode = MODE_PLAIN;
                end
            end
        end
        exp_w.parse_done = (mode == MODE_DONE);
        exp_w.arg_count  = args_found;
        pending_words.push_back(exp_w);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(out_word_t got);
        out_word_t want;
        if (pending_words.size() == 0) begin
            $display("%0t: result word with nothing expected, got %0h", $time, got);
            errors++;
        end else begin
            want = pending_words.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("arg_start", 8'(want.arg_start), 8'(got.arg_start));
            check_field("arg_index", want.arg_index, got.arg_index);
            check_field("parse_done", 8'(want.parse_done), 8'(got.parse_done));
            check_field("arg_count", want.arg_count, got.arg_count);
        end
    endfunction
endclass

module argument_string_tokenizer_top_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 12;
    localparam int SEG_WORDS    = 155;
    localparam int SETTLE_TICKS = 6;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_index;
    logic [7:0] cfg_data;

    arg_scoreboard sb = new();

    int         idle_pct;
    int         stall_pct;
    int         words_sent;
    int         cycles;
    logic [7:0] cur_term;
    logic       str_first;

    argument_string_tokenizer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Sample handshakes on pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_input(s_data);
            if (m_valid && m_ready)
                sb.check_result(m_data);
        end
    end

    task automatic push_byte(input logic first, input logic [7:0] ch);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{first_byte: first, char_byte: ch};
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        push_byte(str_first, ch);
        str_first = 1'b0;
    endtask

    // Wait for every expected word, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_words.size() != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] mx, input logic [7:0] tm);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_ARGS;
        cfg_data  <= mx;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_TERMINATOR;
        cfg_data  <= tm;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_term = tm;
    endtask

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 9))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_DQUOTE;
            3: return CH_SQUOTE;
            4: return CH_BSLASH;
            5: return cur_term;
            6: return CH_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    // Byte that keeps a plain run going; a run may not open with a quote or backslash
    function automatic logic [7:0] plain_char(input bit opening);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == cur_term ||
               (opening && (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH)));
        return c;
    endfunction

    task automatic send_string();
        int         n_args;
        int         len;
        int         kind;
        logic [7:0] q;
        logic [7:0] c;
        str_first = 1'b1;
        repeat ($urandom_range(0, 2)) put_char(blank_char());
        n_args = $urandom_range(0, 6);
        for (int k = 0; k < n_args; k++) begin
            kind = $urandom_range(0, 2);
            case (kind)
                0: begin
                    put_char(plain_char(1'b1));
                    repeat ($urandom_range(0, 5)) put_char(plain_char(1'b0));
                end
                1: begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    put_char(q);
                    len = $urandom_range(0, 5);
                    for (int j = 0; j < len; j++) begin
                        if ($urandom_range(0, 4) == 0) begin
                            put_char(CH_BSLASH);
                            put_char(8'($urandom_range(1, 255)));
                        end else begin
                            do c = 8'($urandom_range(1, 255)); while (c == q);
                            put_char(c);
                        end
                    end
                    put_char(q);
                end
                default: begin
                    put_char(CH_BSLASH);
                    put_char(8'($urandom_range(1, 255)));
                end
            endcase
            // a plain run needs a blank before the next argument
            repeat ($urandom_range(kind == 0 ? 1 : 0, 3)) put_char(blank_char());
        end
        put_char($urandom_range(0, 3) == 0 ? CH_NUL : cur_term);
        repeat ($urandom_range(0, 3)) put_char(any_char());
    endtask

    task automatic send_noise();
        repeat ($urandom_range(4, 12))
            push_byte($urandom_range(0, 7) == 0, any_char());
    endtask

    task automatic pick_config(input int seg, output logic [7:0] mx, output logic [7:0] tm);
        case (seg)
            0:  begin mx = MAX_ARGS_RESET; tm = TERMINATOR_RESET; end
            1:  begin mx = 8'd255; tm = 8'd255; end
            2:  begin mx = 8'd0;   tm = 8'd1;   end
            3:  begin mx = 8'd1;   tm = CH_NUL; end
            4:  begin mx = 8'd2;   tm = CH_SPACE; end
            5:  begin mx = 8'd3;   tm = CH_DQUOTE; end
            6:  begin mx = 8'd255; tm = CH_BSLASH; end
            7:  begin mx = 8'd5;   tm = CH_TAB; end
            9:  begin mx = 8'd4;   tm = CH_NUL; end
            10: begin mx = 8'd255; tm = CH_SQUOTE; end
            default: begin
                mx = 8'($urandom_range(0, 255));
                tm = 8'($urandom_range(1, 255));
            end
        endcase
    endtask

    initial begin
        logic [7:0] mx;
        logic [7:0] tm;
        int         seg_end;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_MAX_ARGS;
        cfg_data   = 8'd0;
        idle_pct   = 0;
        stall_pct  = 0;
        words_sent = 0;
        cycles     = 0;
        cur_term   = TERMINATOR_RESET;
        str_first  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed string at reset settings
        push_byte(1'b1, CH_SPACE);
        push_byte(1'b0, 8'h61);
        push_byte(1'b0, 8'hFF);
        push_byte(1'b0, CH_TAB);
        push_byte(1'b0, CH_DQUOTE);      // quoted span with escaped quote
        push_byte(1'b0, CH_BSLASH);
        push_byte(1'b0, CH_DQUOTE);
        push_byte(1'b0, TERMINATOR_RESET); // terminator inside quotes
        push_byte(1'b0, CH_DQUOTE);
        push_byte(1'b0, CH_SQUOTE);      // next argument with no blank between
        push_byte(1'b0, CH_SQUOTE);
        push_byte(1'b0, CH_BSLASH);      // escape argument
        push_byte(1'b0, CH_SPACE);
        push_byte(1'b0, CH_BSLASH);      // backslash then zero
        push_byte(1'b0, CH_NUL);
        push_byte(1'b0, 8'h80);          // passes through after the stop
        push_byte(1'b1, TERMINATOR_RESET);
        push_byte(1'b1, CH_DQUOTE);      // quote never closed
        push_byte(1'b0, 8'h7A);
        push_byte(1'b0, CH_NUL);
        push_byte(1'b1, CH_SQUOTE);
        push_byte(1'b0, CH_BSLASH);
        push_byte(1'b0, CH_NUL);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 3)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            settle();
            pick_config(seg, mx, tm);
            set_config(mx, tm);
            seg_end = words_sent + SEG_WORDS;
            while (words_sent < seg_end) begin
                if ($urandom_range(0, 4) == 0)
                    send_noise();
                else
                    send_string();
            end
        end

        settle();
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: argument_string_tokenizer_top.f
rtl/core/ast_pkg.sv
rtl/core/ast_step.sv
rtl/core/argument_string_tokenizer_top.sv
test/argument_string_tokenizer_top_tb.sv
